FILE: rtl/rgba_window_dilate_erode_macros.svh
// assertion macros for the rgba window dilate/erode block
// no dependencies; included by modules that carry assertions
`ifndef RGBA_WINDOW_DILATE_ERODE_MACROS_SVH
`define RGBA_WINDOW_DILATE_ERODE_MACROS_SVH

// condition holds at every clock edge outside reset
`define RWDE_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define RWDE_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define RWDE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rwde_pkg.sv
// shared types, constants and channel merge functions for the dilate/erode block
// no dependencies; imported by every module of the block
package rwde_pkg;

  localparam int MAX_RADIUS  = 15;
  localparam int STORE_DEPTH = 2 * MAX_RADIUS;
  localparam int PIX_W       = 32;
  localparam int CH_W        = 8;
  localparam int NUM_CH      = PIX_W / CH_W;
  localparam int NUM_LANES   = 4;
  localparam int LANE_ELEMS  = 8;
  localparam int WIN_ELEMS   = NUM_LANES * LANE_ELEMS;
  localparam int RADIUS_W    = 4;
  localparam int POS_W       = 5;
  localparam int AGE_W       = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 4;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    pixel_t pixel_in;
    logic   line_end;
  } in_item_t;

  typedef struct packed {
    pixel_t pixel_out;
    logic   run_last;
    logic   line_done;
  } out_item_t;

  // flags that travel with a result through the lane and merge stages
  typedef struct packed {
    logic run_last;
    logic line_done;
  } res_tag_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef enum logic {
    OP_DILATE,
    OP_ERODE
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS    = 1'b0,
    REG_OPERATION = 1'b1
  } reg_idx_e;

  // per-channel max (dilate) or min (erode) of two pixels
  function automatic pixel_t chan_merge(pixel_t a, pixel_t b, logic erode);
    pixel_t          res;
    logic [CH_W-1:0] ca;
    logic [CH_W-1:0] cb;
    res = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      ca = a[c*CH_W +: CH_W];
      cb = b[c*CH_W +: CH_W];
      if (erode) begin
        res[c*CH_W +: CH_W] = (ca < cb) ? ca : cb;
      end else begin
        res[c*CH_W +: CH_W] = (ca > cb) ? ca : cb;
      end
    end
    return res;
  endfunction

  // neutral element of the merge
  function automatic pixel_t merge_ident(logic erode);
    return erode ? '1 : '0;
  endfunction

endpackage

FILE: rtl/rwde_lane.sv
// one reduction lane: masked max/min over a slice of the window, registered
// depends on rwde_pkg
module rwde_lane import rwde_pkg::*; (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic                  erode_i,
  input  logic [LANE_ELEMS-1:0] mask_i,
  input  pixel_t                elems_i [LANE_ELEMS],
  output pixel_t                red_o
);

  pixel_t lvl0 [LANE_ELEMS];
  pixel_t lvl1 [LANE_ELEMS/2];
  pixel_t lvl2 [LANE_ELEMS/4];
  pixel_t red_d;
  pixel_t red_q;

  // masked elements become the neutral value
  always_comb begin
    for (int i = 0; i < LANE_ELEMS; i++) begin
      lvl0[i] = mask_i[i] ? elems_i[i] : merge_ident(erode_i);
    end
  end

  // three-level pairwise tree
  always_comb begin
    for (int i = 0; i < LANE_ELEMS/2; i++) begin
      lvl1[i] = chan_merge(lvl0[2*i], lvl0[2*i+1], erode_i);
    end
    for (int i = 0; i < LANE_ELEMS/4; i++) begin
      lvl2[i] = chan_merge(lvl1[2*i], lvl1[2*i+1], erode_i);
    end
    red_d = chan_merge(lvl2[0], lvl2[1], erode_i);
  end

  // lane result register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      red_q <= red_d;
    end
  end

  assign red_o = red_q;

endmodule

FILE: rtl/rwde_merge.sv
// merge stage: combines the lane results and holds the output item register
// depends on rwde_pkg
module rwde_merge import rwde_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      erode_i,
  input  logic      valid_i,
  input  res_tag_t  tag_i,
  input  pixel_t    lanes_i [NUM_LANES],
  output logic      ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  pixel_t    pair [NUM_LANES/2];
  out_item_t item_d;
  out_item_t item_q;
  logic      valid_q;

  // two-level tree over the lanes
  always_comb begin
    for (int i = 0; i < NUM_LANES/2; i++) begin
      pair[i] = chan_merge(lanes_i[2*i], lanes_i[2*i+1], erode_i);
    end
    item_d.pixel_out = chan_merge(pair[0], pair[1], erode_i);
    item_d.run_last  = tag_i.run_last;
    item_d.line_done = tag_i.line_done;
  end

  assign ready_o = !valid_q || out_ready_i;

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

FILE: rtl/rgba_window_dilate_erode.sv
// top level of the one-line dilate/erode block on packed four-channel pixels
// depends on rwde_pkg, rwde_lane, rwde_merge and the macros header
//
// Usage: pixels of a line enter on the in channel (valid/ready), one item per pixel,
// line_end set on the last pixel. Result items leave on the out channel (valid/ready);
// output x appears once pixel x+radius is taken, and the last pixel of the line
// flushes every pending output, run_last marking the last result of an item and
// line_done the final result of the line.
// Configuration (radius, operation) goes through the write port while the block is idle.
// Throughput: an item is accepted, then its results are issued into the lanes one per
// cycle while the lane stage can advance; an item causing no result is only accepted.
// Each issued result passes four 8-element lanes and the lane register, then the
// merge/output register.
// The 30-pixel history is a shift register, so nothing needs clearing after reset;
// reset sets radius 1, dilate, and the line position to the start of a line.
// When the receiver stalls, the output register holds, the lane stage and the
// sequencer stop, and no new item is taken until the current one has issued all.
module rgba_window_dilate_erode import rwde_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

`include "rgba_window_dilate_erode_macros.svh"

  // configuration
  logic [RADIUS_W-1:0] radius_q;
  op_e                 op_q;
  logic                erode;

  // sequencer state
  state_e              state_q;
  state_e              state_d;
  logic                main_pend_q;
  logic [POS_W-1:0]    flush_left_q;
  logic [RADIUS_W-1:0] d_q;
  logic [POS_W-1:0]    pos_q;
  pixel_t              cur_q;
  logic                last_q;

  // history
  pixel_t              store_q [STORE_DEPTH];
  pixel_t              elems   [WIN_ELEMS];

  // accept decode
  logic                in_fire;
  logic                n_lt_r;
  logic                acc_main;
  logic [POS_W-1:0]    acc_flush;
  logic [RADIUS_W-1:0] acc_d;
  logic                acc_none;

  // issue
  logic                issue_valid;
  logic                issue_fire;
  logic [AGE_W-1:0]    two_r;
  logic [AGE_W-1:0]    d_plus_r;
  logic [AGE_W-1:0]    max_age;
  logic [WIN_ELEMS-1:0] incl;
  res_tag_t            issue_tag;
  logic                issue_final;

  // store update
  logic                shift_en;
  pixel_t              shift_pix;
  logic [POS_W-1:0]    pos_inc;

  // lane / merge stage
  logic                lane_valid_q;
  res_tag_t            lane_tag_q;
  logic                lane_adv;
  logic                merge_ready;
  pixel_t              lane_red [NUM_LANES];

  assign erode = (op_q == OP_ERODE);

  // configuration registers; radius is 4 bits, so it never exceeds MAX_RADIUS
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_W'(1);
      op_q     <= OP_DILATE;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_RADIUS:    radius_q <= cfg_data_i[RADIUS_W-1:0];
        REG_OPERATION: op_q     <= op_e'(cfg_data_i[0]);
        default:       ;
      endcase
    end
  end

  // sequencer outputs
  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    issue_valid = (state_q == ST_RUN);
  end

  assign in_fire    = in_valid_i && in_ready_o;
  assign issue_fire = issue_valid && lane_adv;

  // result plan of an incoming item
  always_comb begin
    n_lt_r    = pos_q < POS_W'(radius_q);
    acc_main  = !n_lt_r;
    acc_d     = n_lt_r ? pos_q[RADIUS_W-1:0] : radius_q - RADIUS_W'(1);
    acc_none  = n_lt_r && !in_item_i.line_end;
    if (in_item_i.line_end) begin
      acc_flush = n_lt_r ? pos_q + POS_W'(1) : POS_W'(radius_q);
    end else begin
      acc_flush = '0;
    end
  end

  // window extent and flags of the result being issued
  always_comb begin
    two_r    = {radius_q, 1'b0};
    d_plus_r = AGE_W'(d_q) + AGE_W'(radius_q);
    if (main_pend_q) begin
      max_age            = (two_r < pos_q) ? two_r : pos_q;
      issue_tag.run_last = (flush_left_q == '0);
    end else begin
      max_age            = (d_plus_r < pos_q) ? d_plus_r : pos_q;
      issue_tag.run_last = (flush_left_q == POS_W'(1));
    end
    issue_tag.line_done = issue_tag.run_last && last_q;
    issue_final         = issue_fire && issue_tag.run_last;
    for (int k = 0; k < WIN_ELEMS; k++) begin
      incl[k] = AGE_W'(k) <= max_age;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire && !acc_none) state_d = ST_RUN;
      ST_RUN:  if (issue_final) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      main_pend_q  <= 1'b0;
      flush_left_q <= '0;
      d_q          <= '0;
      pos_q        <= '0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        main_pend_q  <= acc_main;
        flush_left_q <= acc_flush;
        d_q          <= acc_d;
      end else if (issue_fire) begin
        if (main_pend_q) begin
          main_pend_q <= 1'b0;
        end else begin
          flush_left_q <= flush_left_q - POS_W'(1);
          d_q          <= d_q - RADIUS_W'(1);
        end
      end
      if (in_fire && acc_none) begin
        pos_q <= pos_inc;
      end else if (issue_final) begin
        pos_q <= last_q ? '0 : pos_inc;
      end
    end
  end

  // current pixel and its line end flag
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cur_q  <= in_item_i.pixel_in;
      last_q <= in_item_i.line_end;
    end
  end

  // history shift: at accept for items with no result, else at the last issue unless the item ends the line
  always_comb begin
    pos_inc   = (pos_q == POS_W'(STORE_DEPTH)) ? pos_q : pos_q + POS_W'(1);
    shift_en  = (in_fire && acc_none) || (issue_final && !last_q);
    shift_pix = in_ready_o ? in_item_i.pixel_in : cur_q;
  end

  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      store_q[0] <= shift_pix;
      for (int i = 1; i < STORE_DEPTH; i++) begin
        store_q[i] <= store_q[i-1];
      end
    end
  end

  // window by age: current pixel, then stored pixels, top slot always masked
  always_comb begin
    elems[0] = cur_q;
    for (int k = 1; k <= STORE_DEPTH; k++) begin
      elems[k] = store_q[k-1];
    end
    for (int k = STORE_DEPTH + 1; k < WIN_ELEMS; k++) begin
      elems[k] = '0;
    end
  end

  // reduction lanes
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    rwde_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (issue_fire),
      .erode_i (erode),
      .mask_i  (incl[g*LANE_ELEMS +: LANE_ELEMS]),
      .elems_i (elems[g*LANE_ELEMS +: LANE_ELEMS]),
      .red_o   (lane_red[g])
    );
  end

  // lane stage valid and flags
  assign lane_adv = !lane_valid_q || merge_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_valid_q <= 1'b0;
    end else if (lane_adv) begin
      lane_valid_q <= issue_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_fire) begin
      lane_tag_q <= issue_tag;
    end
  end

  // merge and output register
  rwde_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .erode_i     (erode),
    .valid_i     (lane_valid_q),
    .tag_i       (lane_tag_q),
    .lanes_i     (lane_red),
    .ready_o     (merge_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // checks
  `RWDE_ASSERT_ALWAYS(a_pos_range, clk_i, rst_ni, pos_q <= POS_W'(STORE_DEPTH),
    "line position beyond history depth")
  `RWDE_ASSERT_IMPLY(a_done_is_last, clk_i, rst_ni, lane_valid_q && lane_tag_q.line_done,
    lane_tag_q.run_last, "line_done without run_last")
  `RWDE_ASSERT_NEXT(a_final_idle, clk_i, rst_ni, issue_final, in_ready_o,
    "sequencer not idle after last result of an item")
  `RWDE_ASSERT_NEXT(a_line_restart, clk_i, rst_ni, issue_final && last_q, pos_q == '0,
    "line position not cleared after line end")

endmodule

FILE: verif/rgba_window_dilate_erode_check.sv
// result checker for rgba_window_dilate_erode: follows config writes and accepted pixel
// items, predicts the window max/min results and compares them on the out channel
// depends on rwde_pkg
module rgba_window_dilate_erode_check import rwde_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_item_t              in_item_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_item_t             out_item_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);

  localparam int unsigned MAX_REPORTS = 30;

  // predicted block state: pixels of the current line, newest first
  pixel_t              line_history [STORE_DEPTH];
  int unsigned         line_fill;
  logic [RADIUS_W-1:0] win_radius;
  op_e                 win_op;
  out_item_t           expected_results_q [$];
  out_item_t           oldest;

  // per-channel max (dilate) or min (erode) of two pixels
  function automatic pixel_t channel_extreme(pixel_t a, pixel_t b, logic erode);
    pixel_t res;
    for (int c = 0; c < NUM_CH; c++) begin
      if ((a[c*CH_W +: CH_W] > b[c*CH_W +: CH_W]) ^ erode) begin
        res[c*CH_W +: CH_W] = a[c*CH_W +: CH_W];
      end else begin
        res[c*CH_W +: CH_W] = b[c*CH_W +: CH_W];
      end
    end
    return res;
  endfunction

  // combine the incoming pixel with the stored ones up to the given age
  function automatic pixel_t window_extreme(pixel_t cur, int unsigned depth, logic erode);
    pixel_t acc;
    acc = cur;
    if (depth > STORE_DEPTH) depth = STORE_DEPTH;
    for (int unsigned age = 1; age <= depth; age++) begin
      acc = channel_extreme(acc, line_history[age-1], erode);
    end
    return acc;
  endfunction

  task automatic report_mismatch(string what, logic [PIX_W-1:0] got, logic [PIX_W-1:0] want);
    fail_count_o++;
    if (fail_count_o <= MAX_REPORTS) begin
      $display("%0t: %s: got %h, expected %h", $time, what, got, want);
    end
  endtask

  // expected results of one pixel item, then the history update
  task automatic predict_results(in_item_t item);
    pixel_t      outs [$];
    int unsigned r;
    int unsigned n;
    int unsigned span;
    int          d;
    logic        erode;
    out_item_t   res;
    erode = (win_op == OP_ERODE);
    r = (win_radius > MAX_RADIUS) ? MAX_RADIUS : win_radius;
    n = line_fill;
    // output n - r is complete once this pixel arrives
    if (n >= r) begin
      span = (2 * r < n) ? 2 * r : n;
      outs.push_back(window_extreme(item.pixel_in, span, erode));
    end
    if (item.line_end) begin
      // flush the outputs whose windows reach past the line end
      d = (n < r) ? int'(n) : int'(r) - 1;
      while (d >= 0) begin
        span = int'(d) + r;
        if (span > n) span = n;
        outs.push_back(window_extreme(item.pixel_in, span, erode));
        d--;
      end
      line_fill = 0;
    end else begin
      for (int i = STORE_DEPTH - 1; i > 0; i--) line_history[i] = line_history[i-1];
      line_history[0] = item.pixel_in;
      line_fill = (n + 1 > STORE_DEPTH) ? STORE_DEPTH : n + 1;
    end
    foreach (outs[k]) begin
      res.pixel_out = outs[k];
      res.run_last  = (k == outs.size() - 1);
      res.line_done = (k == outs.size() - 1) && item.line_end;
      expected_results_q.push_back(res);
    end
  endtask

  // follow config, predict on input handshakes, compare on output handshakes
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_radius   = 4'd1;
      win_op       = OP_DILATE;
      line_fill    = 0;
      expected_results_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_RADIUS:    win_radius = cfg_data_i[RADIUS_W-1:0];
          REG_OPERATION: win_op     = op_e'(cfg_data_i[0]);
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_results(in_item_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_results_q.size() == 0) begin
          report_mismatch("result with nothing expected", out_item_i.pixel_out, '0);
        end else begin
          oldest = expected_results_q.pop_front();
          if (out_item_i.pixel_out !== oldest.pixel_out) begin
            report_mismatch("pixel_out", out_item_i.pixel_out, oldest.pixel_out);
          end
          if (out_item_i.run_last !== oldest.run_last) begin
            report_mismatch("run_last", PIX_W'(out_item_i.run_last), PIX_W'(oldest.run_last));
          end
          if (out_item_i.line_done !== oldest.line_done) begin
            report_mismatch("line_done", PIX_W'(out_item_i.line_done),
                            PIX_W'(oldest.line_done));
          end
        end
      end
      pending_o = expected_results_q.size();
    end
  end

endmodule

FILE: verif/rgba_window_dilate_erode_tb.sv
// testbench top for rgba_window_dilate_erode: directed and random pixel lines, random
// idling on both channels, config changes between phases; verdict from the checker
// depends on rwde_pkg, rgba_window_dilate_erode and rgba_window_dilate_erode_check
module rgba_window_dilate_erode_tb;
  import rwde_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 100;
  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned LONG_HOLD     = 300;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_item;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned           fail_count;
  int unsigned           pending;
  bit                    in_gappy;
  bit                    out_gappy;
  int unsigned           hold_request;
  int unsigned           random_sent;
  int unsigned           cycle_count;

  rgba_window_dilate_erode dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  rgba_window_dilate_erode_check u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // channel values biased toward the extremes
  function automatic pixel_t random_pixel();
    pixel_t px;
    for (int c = 0; c < NUM_CH; c++) begin
      case ($urandom_range(0, 3))
        0:       px[c*CH_W +: CH_W] = '0;
        1:       px[c*CH_W +: CH_W] = '1;
        default: px[c*CH_W +: CH_W] = CH_W'($urandom);
      endcase
    end
    return px;
  endfunction

  // offer one pixel item after a random gap and hold it until taken
  task automatic send_pixel(pixel_t px, logic last);
    int unsigned gap;
    gap = in_gappy ? $urandom_range(0, 8) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= in_item_t'{pixel_in: px, line_end: last};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // stop offering, wait for every expected result, then let the pipeline settle
  task automatic finish_phase();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // one random setting and a few lines; the last line is sometimes cut short
  task automatic random_phase(bit pressure);
    int unsigned         lines;
    int unsigned         len;
    int unsigned         sel;
    bit                  cut;
    logic [RADIUS_W-1:0] r;
    logic [CFG_DATA_W-1:0] op_data;
    finish_phase();
    sel = $urandom_range(0, 4);
    if (pressure || sel == 1) r = 4'd15;
    else if (sel == 0) r = 4'd0;
    else r = RADIUS_W'($urandom_range(1, 14));
    op_data = CFG_DATA_W'($urandom_range(0, 15));
    write_reg(REG_RADIUS, CFG_DATA_W'(r));
    write_reg(REG_OPERATION, op_data);
    in_gappy  = pressure ? 1'b0 : ($urandom_range(0, 2) != 0);
    out_gappy = pressure ? 1'b0 : ($urandom_range(0, 2) != 0);
    if (pressure) hold_request = LONG_HOLD;
    lines = pressure ? 1 : $urandom_range(1, 3);
    for (int l = 0; l < lines; l++) begin
      if (pressure) len = 36;
      else if ($urandom_range(0, 5) == 0) len = $urandom_range(30, 40);
      else len = $urandom_range(1, 12);
      cut = !pressure && (l == lines - 1) && ($urandom_range(0, 5) == 0);
      for (int i = 0; i < len; i++) begin
        send_pixel(random_pixel(), (i == len - 1) && !cut);
        random_sent++;
      end
    end
  endtask

  // receiver: random stall per result, plus any long hold-off requested
  initial begin
    int unsigned idle;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      idle = out_gappy ? $urandom_range(0, 8) : 0;
      idle += hold_request;
      hold_request = 0;
      @(negedge clk);
      if (idle > 0) begin
        out_ready <= 1'b0;
        repeat (idle) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("rgba_window_dilate_erode_tb failed");
    $finish;
  end

  // reset and stimulus
  initial begin
    in_valid     = 1'b0;
    in_item      = '0;
    cfg_we       = 1'b0;
    cfg_idx      = REG_RADIUS;
    cfg_data     = '0;
    rst_n        = 1'b0;
    in_gappy     = 1'b0;
    out_gappy    = 1'b0;
    hold_request = 0;
    random_sent  = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // radius 1 dilate: channel extremes, then a line of one pixel
    write_reg(REG_RADIUS, 4'd1);
    write_reg(REG_OPERATION, CFG_DATA_W'(OP_DILATE));
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'hFFFF_FFFF, 1'b0);
    send_pixel(32'h1234_5678, 1'b0);
    send_pixel(32'h80FF_007F, 1'b1);
    send_pixel(32'hA5A5_A5A5, 1'b1);
    finish_phase();

    // radius 0 erode: each pixel is its own window; upper data bits are ignored
    write_reg(REG_RADIUS, 4'd0);
    write_reg(REG_OPERATION, {3'b110, OP_ERODE});
    send_pixel(32'hFFFF_FFFF, 1'b0);
    send_pixel(32'h00FF_00FF, 1'b1);
    finish_phase();

    // radius 15 on a 3-pixel line: every output comes with the last pixel
    write_reg(REG_RADIUS, 4'd15);
    write_reg(REG_OPERATION, CFG_DATA_W'(OP_DILATE));
    send_pixel(32'h0102_0304, 1'b0);
    send_pixel(32'hF0E0_D0C0, 1'b0);
    send_pixel(32'h7F7F_7F7F, 1'b1);
    finish_phase();

    // radius 2 erode, changed to radius 5 dilate halfway through a line
    write_reg(REG_RADIUS, 4'd2);
    write_reg(REG_OPERATION, CFG_DATA_W'(OP_ERODE));
    send_pixel(32'hFF00_FF00, 1'b0);
    send_pixel(32'h00FF_00FF, 1'b0);
    send_pixel(32'h8080_8080, 1'b0);
    finish_phase();
    write_reg(REG_RADIUS, 4'd5);
    write_reg(REG_OPERATION, CFG_DATA_W'(OP_DILATE));
    send_pixel(32'h0000_00FF, 1'b0);
    send_pixel(32'hFF00_0000, 1'b0);
    send_pixel(32'h0011_2233, 1'b1);

    // random phases, the first one with a long receiver hold-off
    random_phase(1'b1);
    while (random_sent < RANDOM_ITEMS) random_phase(1'b0);
    finish_phase();
    repeat (20) @(negedge clk);

    if (fail_count == 0) begin
      $display("rgba_window_dilate_erode_tb passed");
    end else begin
      $display("rgba_window_dilate_erode_tb failed");
    end
    $finish;
  end

endmodule
